### sv/h264pse_pkg.sv
// Shared types and constants for the H.264 parameter set extractor.
// No dependencies; imported by the top level and its port checker.
package h264pse_pkg;

   // NAL header and start code bytes
   localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
   localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
   localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
   localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;
   localparam logic [7:0] SC_ZERO       = 8'h00;
   localparam logic [7:0] SC_ONE        = 8'h01;

   // rsp_out_kind codes
   localparam logic OUT_KIND_STATUS = 1'b0;
   localparam logic OUT_KIND_DATA   = 1'b1;

   typedef enum logic [1:0] {
      NAL_NONE,
      NAL_SPS,
      NAL_PPS,
      NAL_OTHER
   } nal_kind_type;

   // where the byte of a queued result item comes from
   typedef enum logic [1:0] {
      SRC_CONST,
      SRC_SPS,
      SRC_PPS
   } item_src_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_kind;
      logic       run_last;
      logic       key_frame;
      logic       params_ready;
      logic       overflow;
   } item_type;

endpackage

### sv/h264pse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the SPS and PPS byte stores.
module h264pse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/h264_parameter_set_extractor_top.sv
// Annex-B scanner that captures SPS/PPS into byte RAMs and replays them as extradata.
// Depends on h264pse_pkg and h264pse_ram.
//
// Takes one packet byte per clock while scanning. When the byte marked packet_end
// is taken, req_stall goes high for the result run: 4 + SPS length + 4 + PPS
// length + 1 items when the pair is sent, a single status item otherwise. The run
// moves one item per clock while rsp_stall is low; the SPS and PPS bytes come from
// two-port RAMs with a registered read, and a prefetch stage ahead of the output
// register hides that read register. The stores need no clearing after reset.
module h264_parameter_set_extractor_top
   import h264pse_pkg::*;
#(
   parameter int MAX_SPS_BYTES = 32,
   parameter int MAX_PPS_BYTES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_packet_end,
   input  logic       req_rearm,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_kind,
   output logic       rsp_run_last,
   output logic       rsp_key_frame,
   output logic       rsp_params_ready,
   output logic       rsp_overflow
);

   localparam int SPS_AW  = $clog2(MAX_SPS_BYTES);
   localparam int PPS_AW  = $clog2(MAX_PPS_BYTES);
   localparam int SPS_LW  = $clog2(MAX_SPS_BYTES + 1);
   localparam int PPS_LW  = $clog2(MAX_PPS_BYTES + 1);
   localparam int MAX_SET = (MAX_SPS_BYTES > MAX_PPS_BYTES) ? MAX_SPS_BYTES : MAX_PPS_BYTES;
   localparam int RUN_W   = $clog2(MAX_SET + 5);
   localparam int IDX_W0  = (SPS_AW > PPS_AW) ? SPS_AW : PPS_AW;
   localparam int IDX_W   = (IDX_W0 > 2) ? IDX_W0 : 2;
   localparam int CNT_W   = IDX_W + 1;

   // a set may run 4 bytes past its store so a trailing start code can be cut
   localparam logic [RUN_W-1:0] SPS_CAP   = RUN_W'(MAX_SPS_BYTES + 4);
   localparam logic [RUN_W-1:0] PPS_CAP   = RUN_W'(MAX_PPS_BYTES + 4);
   localparam logic [RUN_W-1:0] SPS_LIM   = RUN_W'(MAX_SPS_BYTES);
   localparam logic [RUN_W-1:0] PPS_LIM   = RUN_W'(MAX_PPS_BYTES);
   localparam logic [RUN_W-1:0] CUT_SHORT = RUN_W'(2);
   localparam logic [RUN_W-1:0] CUT_LONG  = RUN_W'(3);
   localparam logic [RUN_W-1:0] LONG_MIN  = RUN_W'(4);
   localparam logic [IDX_W-1:0] SC_LAST   = IDX_W'(3);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZS1,
      ST_SPS,
      ST_ZS2,
      ST_PPS,
      ST_STAT
   } emit_state_type;

   // scan state
   logic [23:0]       hist_ff, hist_in;
   logic [1:0]        hist_cnt_ff, hist_cnt_in;
   logic [SPS_LW-1:0] sps_len_ff, sps_len_in;
   logic [PPS_LW-1:0] pps_len_ff, pps_len_in;
   nal_kind_type      nal_kind_ff, nal_kind_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic              hdr_ff, hdr_in;
   logic              pair_ff, pair_in;
   logic              done_ff, done_in;
   logic              key_ff, key_in;
   logic              ovf_ff, ovf_in;

   // emission state
   emit_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SPS_LW-1:0] em_sps_len_ff, em_sps_len_in;
   logic [PPS_LW-1:0] em_pps_len_ff, em_pps_len_in;
   logic              em_key_ff, em_key_in;
   logic              em_ready_ff, em_ready_in;
   logic              em_ovf_ff, em_ovf_in;

   // prefetch stage and output register
   logic              p_valid_ff, p_valid_in;
   item_src_type      p_src_ff, p_src_in;
   item_type          p_item_ff, p_item_in;
   logic              o_valid_ff, o_valid_in;
   item_type          o_item_ff, o_item_in;

   // scan combinational
   logic              in_acc;
   logic [7:0]        b1, b2, b3;
   logic              start_w, done_eff, capture_w;
   logic [4:0]        nal_type_w;
   nal_kind_type      kind_a;
   logic [RUN_W-1:0]  run_base, run_a, cut_w, len_w;
   logic              sps_we, pps_we;
   logic [SPS_LW-1:0] sps_len_nx;
   logic [PPS_LW-1:0] pps_len_nx;
   logic              ovf_nx, pair_nx, key_nx, hdr_nx, ready_w;

   // emission combinational
   logic              o_free, issue;
   logic [CNT_W-1:0]  idx_next;
   logic              sps_re, pps_re;
   logic [7:0]        sps_rd_data, pps_rd_data;
   logic [7:0]        o_byte;

   assign in_acc    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      b1         = hist_ff[7:0];
      b2         = hist_ff[15:8];
      b3         = hist_ff[23:16];
      start_w    = !req_packet_end && req_data_byte == SC_ONE && hist_cnt_ff >= 2'd2
                   && b1 == SC_ZERO && b2 == SC_ZERO;
      done_eff   = req_rearm ? 1'b0 : done_ff;
      nal_type_w = 5'(req_data_byte & NAL_TYPE_MASK);
      capture_w  = !done_eff && !pair_ff;

      hdr_nx   = hdr_ff;
      key_nx   = key_ff;
      kind_a   = nal_kind_ff;
      run_base = run_ff;
      run_a    = run_ff;
      cut_w    = '0;
      sps_we   = 1'b0;
      pps_we   = 1'b0;

      if (start_w) begin
         hdr_nx = 1'b1;
         // a zero ahead of 00 00 01 belongs to the start code
         if (hist_cnt_ff == 2'd3 && b3 == SC_ZERO && run_ff >= LONG_MIN) begin
            cut_w = CUT_LONG;
         end else begin
            cut_w = CUT_SHORT;
         end
      end else begin
         if (hdr_ff) begin
            hdr_nx   = 1'b0;
            run_base = '0;
            if (nal_type_w == NAL_TYPE_IDR) begin
               key_nx = 1'b1;
            end
            if (capture_w && nal_type_w == NAL_TYPE_SPS) begin
               kind_a = NAL_SPS;
            end else if (capture_w && nal_type_w == NAL_TYPE_PPS) begin
               kind_a = NAL_PPS;
            end else begin
               kind_a = NAL_OTHER;
            end
         end
         run_a = run_base;
         if (kind_a == NAL_SPS && run_base < SPS_CAP) begin
            sps_we = (run_base < SPS_LIM);
            run_a  = run_base + 1'b1;
         end else if (kind_a == NAL_PPS && run_base < PPS_CAP) begin
            pps_we = (run_base < PPS_LIM);
            run_a  = run_base + 1'b1;
         end
      end

      // close the NAL at a start code or at packet end
      len_w      = (run_a > cut_w) ? (run_a - cut_w) : '0;
      sps_len_nx = sps_len_ff;
      pps_len_nx = pps_len_ff;
      ovf_nx     = ovf_ff;
      pair_nx    = pair_ff;
      nal_kind_in = kind_a;
      run_in      = run_a;
      if (start_w || req_packet_end) begin
         if (kind_a == NAL_SPS) begin
            if (len_w > SPS_LIM) begin
               ovf_nx = 1'b1;
            end else begin
               sps_len_nx = SPS_LW'(len_w);
            end
         end else if (kind_a == NAL_PPS) begin
            if (len_w > PPS_LIM) begin
               ovf_nx = 1'b1;
            end else begin
               pps_len_nx = PPS_LW'(len_w);
            end
         end
         if ((kind_a == NAL_SPS || kind_a == NAL_PPS) && sps_len_nx != '0
             && pps_len_nx != '0) begin
            pair_nx = 1'b1;
         end
         nal_kind_in = NAL_NONE;
         run_in      = '0;
      end
      ready_w = pair_nx && !ovf_nx && !done_eff;

      hist_in     = {hist_ff[15:0], req_data_byte};
      hist_cnt_in = (hist_cnt_ff == 2'd3) ? hist_cnt_ff : hist_cnt_ff + 2'd1;
      sps_len_in  = sps_len_nx;
      pps_len_in  = pps_len_nx;
      hdr_in      = hdr_nx;
      pair_in     = pair_nx;
      key_in      = key_nx;
      ovf_in      = ovf_nx;
      done_in     = done_eff || (req_packet_end && ready_w);

      if (req_packet_end) begin
         hist_in     = '0;
         hist_cnt_in = '0;
         sps_len_in  = '0;
         pps_len_in  = '0;
         nal_kind_in = NAL_NONE;
         run_in      = '0;
         hdr_in      = 1'b0;
         pair_in     = 1'b0;
         key_in      = 1'b0;
         ovf_in      = 1'b0;
      end
   end

   always_comb begin
      o_free   = !o_valid_ff || !rsp_stall;
      issue    = (state_ff != ST_IDLE) && (!p_valid_ff || o_free);
      idx_next = CNT_W'(idx_ff) + 1'b1;
      sps_re   = issue && state_ff == ST_SPS;
      pps_re   = issue && state_ff == ST_PPS;

      state_in      = state_ff;
      idx_in        = idx_ff;
      em_sps_len_in = em_sps_len_ff;
      em_pps_len_in = em_pps_len_ff;
      em_key_in     = em_key_ff;
      em_ready_in   = em_ready_ff;
      em_ovf_in     = em_ovf_ff;
      p_src_in      = p_src_ff;
      p_item_in     = p_item_ff;

      if (in_acc && req_packet_end) begin
         em_sps_len_in = sps_len_nx;
         em_pps_len_in = pps_len_nx;
         em_key_in     = key_nx;
         em_ready_in   = ready_w;
         em_ovf_in     = ovf_nx;
         idx_in        = '0;
         state_in      = ready_w ? ST_ZS1 : ST_STAT;
      end

      if (issue) begin
         p_src_in  = SRC_CONST;
         p_item_in = '{out_byte: SC_ZERO, out_kind: OUT_KIND_DATA, run_last: 1'b0,
                       key_frame: 1'b0, params_ready: 1'b0, overflow: 1'b0};
         case (state_ff)
            ST_ZS1, ST_ZS2: begin
               p_item_in.out_byte = (idx_ff == SC_LAST) ? SC_ONE : SC_ZERO;
               if (idx_ff == SC_LAST) begin
                  idx_in = '0;
                  if (state_ff == ST_ZS1) begin
                     state_in = (em_sps_len_ff == '0) ? ST_ZS2 : ST_SPS;
                  end else begin
                     state_in = (em_pps_len_ff == '0) ? ST_STAT : ST_PPS;
                  end
               end else begin
                  idx_in = IDX_W'(idx_next);
               end
            end
            ST_SPS: begin
               p_src_in = SRC_SPS;
               if (idx_next == CNT_W'(em_sps_len_ff)) begin
                  idx_in   = '0;
                  state_in = ST_ZS2;
               end else begin
                  idx_in = IDX_W'(idx_next);
               end
            end
            ST_PPS: begin
               p_src_in = SRC_PPS;
               if (idx_next == CNT_W'(em_pps_len_ff)) begin
                  idx_in   = '0;
                  state_in = ST_STAT;
               end else begin
                  idx_in = IDX_W'(idx_next);
               end
            end
            ST_STAT: begin
               p_item_in = '{out_byte: SC_ZERO, out_kind: OUT_KIND_STATUS, run_last: 1'b1,
                             key_frame: em_key_ff, params_ready: em_ready_ff,
                             overflow: em_ovf_ff};
               state_in  = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end

      if (issue) begin
         p_valid_in = 1'b1;
      end else if (p_valid_ff && o_free) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end

      case (p_src_ff)
         SRC_SPS: o_byte = sps_rd_data;
         SRC_PPS: o_byte = pps_rd_data;
         default: o_byte = p_item_ff.out_byte;
      endcase

      o_valid_in = o_valid_ff;
      o_item_in  = o_item_ff;
      if (o_free) begin
         o_valid_in         = p_valid_ff;
         o_item_in          = p_item_ff;
         o_item_in.out_byte = o_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         hist_cnt_ff <= '0;
         sps_len_ff  <= '0;
         pps_len_ff  <= '0;
         nal_kind_ff <= NAL_NONE;
         run_ff      <= '0;
         hdr_ff      <= 1'b0;
         pair_ff     <= 1'b0;
         done_ff     <= 1'b0;
         key_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         p_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         if (in_acc) begin
            hist_ff     <= hist_in;
            hist_cnt_ff <= hist_cnt_in;
            sps_len_ff  <= sps_len_in;
            pps_len_ff  <= pps_len_in;
            nal_kind_ff <= nal_kind_in;
            run_ff      <= run_in;
            hdr_ff      <= hdr_in;
            pair_ff     <= pair_in;
            done_ff     <= done_in;
            key_ff      <= key_in;
            ovf_ff      <= ovf_in;
         end
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
      em_sps_len_ff <= em_sps_len_in;
      em_pps_len_ff <= em_pps_len_in;
      em_key_ff     <= em_key_in;
      em_ready_ff   <= em_ready_in;
      em_ovf_ff     <= em_ovf_in;
      p_src_ff      <= p_src_in;
      p_item_ff     <= p_item_in;
      o_item_ff     <= o_item_in;
   end

   h264pse_ram #(
      .WIDTH (8),
      .DEPTH (MAX_SPS_BYTES)
   ) u_sps_ram (
      .clock   (clock),
      .wr_en   (in_acc && sps_we),
      .wr_addr (run_base[SPS_AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (sps_re),
      .rd_addr (idx_ff[SPS_AW-1:0]),
      .rd_data (sps_rd_data)
   );

   h264pse_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PPS_BYTES)
   ) u_pps_ram (
      .clock   (clock),
      .wr_en   (in_acc && pps_we),
      .wr_addr (run_base[PPS_AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (pps_re),
      .rd_addr (idx_ff[PPS_AW-1:0]),
      .rd_data (pps_rd_data)
   );

   assign rsp_valid        = o_valid_ff;
   assign rsp_out_byte     = o_item_ff.out_byte;
   assign rsp_out_kind     = o_item_ff.out_kind;
   assign rsp_run_last     = o_item_ff.run_last;
   assign rsp_key_frame    = o_item_ff.key_frame;
   assign rsp_params_ready = o_item_ff.params_ready;
   assign rsp_overflow     = o_item_ff.overflow;

endmodule

### sv/h264pse_check.sv
// Port-level checker for the parameter set extractor, bound to its top level.
// Depends on h264pse_pkg.
module h264pse_check
   import h264pse_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       req_packet_end,
   input logic       req_rearm,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_kind,
   input logic       rsp_run_last,
   input logic       rsp_key_frame,
   input logic       rsp_params_ready,
   input logic       rsp_overflow
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_kind) && $stable(rsp_run_last))
      else $error("stalled result item changed");

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_out_kind == OUT_KIND_STATUS
         && rsp_out_byte == SC_ZERO)
      else $error("run end item is not a clean status item");

   a_data_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == OUT_KIND_DATA |-> !rsp_run_last && !rsp_key_frame
         && !rsp_params_ready && !rsp_overflow)
      else $error("extradata item carries status flags");

   a_ready_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_params_ready |-> !rsp_overflow)
      else $error("pair reported ready with overflow");

   // input is held off only after a packet end was taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && req_packet_end))
      else $error("input stalled without a packet end");

endmodule

bind h264_parameter_set_extractor_top h264pse_check u_check (.*);
